// File: sv/afb_pkg.sv
package afb_pkg;

    // Frame kinds carried in the mode field
    typedef enum logic [1:0] {
        MODE_TX     = 2'd0,
        MODE_LOCAL  = 2'd1,
        MODE_REMOTE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DEST_ADDRESS    = 2'd0,
        REG_TRANSMIT_TYPE   = 2'd1,
        REG_LOCAL_CMD_TYPE  = 2'd2,
        REG_REMOTE_CMD_TYPE = 2'd3
    } reg_index_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        B_NEXT = 2'd0,
        B_HEAD = 2'd1,
        B_BODY = 2'd2,
        B_SUM  = 2'd3
    } b_state_t;

    // Frame byte constants
    localparam logic [7:0] SOF_BYTE       = 8'h7E;
    localparam logic [7:0] LEN_HI_BYTE    = 8'h00;
    localparam logic [7:0] FRAME_ID_BYTE  = 8'h10;
    localparam logic [7:0] BCAST_HI_BYTE  = 8'hFF;
    localparam logic [7:0] BCAST_LO_BYTE  = 8'hFE;
    localparam logic [7:0] OPT_TX_BYTE    = 8'h00;
    localparam logic [7:0] OPT_REMOTE_BYTE = 8'h02;
    localparam logic [7:0] ZERO_BYTE      = 8'h00;

    // Length byte: bytes from frame type to last content byte
    localparam logic [7:0] TX_LEN_OFFSET  = 8'd14;
    localparam logic [7:0] LOCAL_LEN_BYTE = 8'd4;
    localparam logic [7:0] REMOTE_LEN_BYTE = 8'd15;
    localparam logic [7:0] AT_CMD_COUNT   = 8'd2;

    // Header byte positions
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] HS_SOF       = 5'd0;
    localparam logic [STEP_W-1:0] HS_LEN_HI    = 5'd1;
    localparam logic [STEP_W-1:0] HS_LEN_LO    = 5'd2;
    localparam logic [STEP_W-1:0] HS_TYPE      = 5'd3;
    localparam logic [STEP_W-1:0] HS_FRAME_ID  = 5'd4;
    localparam logic [STEP_W-1:0] HS_ADDR      = 5'd5;
    localparam logic [STEP_W-1:0] HS_BCAST_HI  = 5'd13;
    localparam logic [STEP_W-1:0] HS_BCAST_LO  = 5'd14;
    localparam logic [STEP_W-1:0] HS_OPT0      = 5'd15;
    localparam logic [STEP_W-1:0] HS_OPT1      = 5'd16;

    // Configuration registers as seen by the back end
    typedef struct packed {
        logic [63:0] dest_address;
        logic [7:0]  transmit_type;
        logic [7:0]  local_cmd_type;
        logic [7:0]  remote_cmd_type;
    } cfg_t;

    // Classified command passed from front to back
    typedef struct packed {
        logic       start;        // emit a header first
        logic       has_content;  // carries a content byte
        logic       last;         // close the frame with a checksum
        mode_t      mode;
        logic [7:0] len_byte;
        logic [7:0] data;
    } cmd_t;

endpackage

// File: sv/afb_front.sv
module afb_front #(
    parameter int MAX_DATA = 241
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  afb_pkg::mode_t    in_mode,
    input  logic              in_first,
    input  logic [7:0]        in_length,
    input  logic [7:0]        in_byte,
    output logic              push,
    output afb_pkg::cmd_t     cmd,
    output logic [7:0]        remaining
);

    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] count;

    // Clip transmit length and pick the frame's content count
    always_comb
    begin
        if (in_mode == afb_pkg::MODE_TX)
        begin
            count = (in_length > 8'(MAX_DATA)) ? 8'(MAX_DATA) : in_length;
        end
        else
        begin
            count = afb_pkg::AT_CMD_COUNT;
        end
    end

    // Classify the item and build the command
    always_comb
    begin
        push            = 1'b0;
        bytes_left_next = bytes_left_reg;
        cmd.start       = in_first;
        cmd.mode        = in_mode;
        cmd.data        = in_byte;
        cmd.has_content = 1'b1;
        cmd.last        = 1'b0;
        unique case (in_mode)
            afb_pkg::MODE_TX:     cmd.len_byte = count + afb_pkg::TX_LEN_OFFSET;
            afb_pkg::MODE_LOCAL:  cmd.len_byte = afb_pkg::LOCAL_LEN_BYTE;
            afb_pkg::MODE_REMOTE: cmd.len_byte = afb_pkg::REMOTE_LEN_BYTE;
            default:              cmd.len_byte = afb_pkg::ZERO_BYTE;
        endcase
        if (in_fire)
        begin
            priority if (in_first)
            begin
                if (in_mode != afb_pkg::MODE_NONE)
                begin
                    push = 1'b1;
                    if (count == 8'd0)
                    begin
                        cmd.has_content = 1'b0;
                        cmd.last        = 1'b1;
                        bytes_left_next = 8'd0;
                    end
                    else
                    begin
                        cmd.last        = (count == 8'd1);
                        bytes_left_next = count - 8'd1;
                    end
                end
            end
            else if (bytes_left_reg != 8'd0)
            begin
                push            = 1'b1;
                cmd.last        = (bytes_left_reg == 8'd1);
                bytes_left_next = bytes_left_reg - 8'd1;
            end
            else
            begin
                // Drop a stray content byte with no open frame
                push = 1'b0;
            end
        end
    end

    // Hold the count of content bytes still owed by the open frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 8'd0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
        end
    end

    assign remaining = bytes_left_reg;

endmodule

// File: sv/afb_queue.sv
module afb_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  afb_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output logic              head_valid,
    output afb_pkg::cmd_t     head_cmd,
    output logic              full,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    afb_pkg::cmd_t   mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign do_push = push && !full;
    assign do_pop  = pop && head_valid;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CW'(DEPTH));
    assign level      = count_reg;

endmodule

// File: sv/afb_back.sv
module afb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  afb_pkg::cfg_t     cfg,
    input  logic              head_valid,
    input  afb_pkg::cmd_t     head_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_end
);

    afb_pkg::b_state_t            state_reg, state_next;
    logic [afb_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [7:0]                   sum_reg, sum_next;
    logic                         valid_reg, valid_next;
    logic [7:0]                   byte_reg;
    logic                         end_reg;

    logic                         adv;
    logic                         emit, summed, clear_sum, emit_end;
    logic [7:0]                   emit_byte;
    logic [7:0]                   hdr_byte, type_byte;
    logic [afb_pkg::STEP_W-1:0]   last_step;
    logic [2:0]                   addr_idx;
    logic [7:0][7:0]              dest_bytes;

    // Output register takes a byte when empty or being drained
    assign adv = !valid_reg || out_ready;

    assign dest_bytes = cfg.dest_address;
    assign addr_idx   = 3'(step_reg - afb_pkg::HS_ADDR);

    // Frame type and final header position for the head command
    always_comb
    begin
        unique case (head_cmd.mode)
            afb_pkg::MODE_LOCAL:
            begin
                type_byte = cfg.local_cmd_type;
                last_step = afb_pkg::HS_FRAME_ID;
            end
            afb_pkg::MODE_REMOTE:
            begin
                type_byte = cfg.remote_cmd_type;
                last_step = afb_pkg::HS_OPT0;
            end
            default:
            begin
                type_byte = cfg.transmit_type;
                last_step = afb_pkg::HS_OPT1;
            end
        endcase
    end

    // Header byte at the current position
    always_comb
    begin
        unique case (step_reg)
            afb_pkg::HS_SOF:      hdr_byte = afb_pkg::SOF_BYTE;
            afb_pkg::HS_LEN_HI:   hdr_byte = afb_pkg::LEN_HI_BYTE;
            afb_pkg::HS_LEN_LO:   hdr_byte = head_cmd.len_byte;
            afb_pkg::HS_TYPE:     hdr_byte = type_byte;
            afb_pkg::HS_FRAME_ID: hdr_byte = afb_pkg::FRAME_ID_BYTE;
            afb_pkg::HS_BCAST_HI: hdr_byte = afb_pkg::BCAST_HI_BYTE;
            afb_pkg::HS_BCAST_LO: hdr_byte = afb_pkg::BCAST_LO_BYTE;
            afb_pkg::HS_OPT0:     hdr_byte = (head_cmd.mode == afb_pkg::MODE_REMOTE) ?
                                             afb_pkg::OPT_REMOTE_BYTE : afb_pkg::OPT_TX_BYTE;
            afb_pkg::HS_OPT1:     hdr_byte = afb_pkg::OPT_TX_BYTE;
            default:              hdr_byte = dest_bytes[3'd7 - addr_idx];
        endcase
    end

    // Byte to emit this cycle and queue pop
    always_comb
    begin
        emit      = 1'b0;
        summed    = 1'b0;
        clear_sum = 1'b0;
        emit_end  = 1'b0;
        emit_byte = afb_pkg::ZERO_BYTE;
        pop       = 1'b0;
        unique case (state_reg)
            afb_pkg::B_NEXT:
            begin
                if (head_valid)
                begin
                    emit = 1'b1;
                    if (head_cmd.start)
                    begin
                        emit_byte = afb_pkg::SOF_BYTE;
                        clear_sum = 1'b1;
                    end
                    else
                    begin
                        emit_byte = head_cmd.data;
                        summed    = 1'b1;
                        pop       = adv;
                    end
                end
            end
            afb_pkg::B_HEAD:
            begin
                emit      = 1'b1;
                emit_byte = hdr_byte;
                summed    = (step_reg >= afb_pkg::HS_TYPE);
                pop       = adv && (step_reg == last_step) && !head_cmd.has_content;
            end
            afb_pkg::B_BODY:
            begin
                emit      = 1'b1;
                emit_byte = head_cmd.data;
                summed    = 1'b1;
                pop       = adv;
            end
            afb_pkg::B_SUM:
            begin
                emit      = 1'b1;
                emit_byte = ~sum_reg;
                emit_end  = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Next sequencer state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        if (adv)
        begin
            unique case (state_reg)
                afb_pkg::B_NEXT:
                begin
                    if (head_valid)
                    begin
                        if (head_cmd.start)
                        begin
                            state_next = afb_pkg::B_HEAD;
                            step_next  = afb_pkg::HS_LEN_HI;
                        end
                        else if (head_cmd.last)
                        begin
                            state_next = afb_pkg::B_SUM;
                        end
                    end
                end
                afb_pkg::B_HEAD:
                begin
                    if (step_reg == last_step)
                    begin
                        state_next = head_cmd.has_content ? afb_pkg::B_BODY : afb_pkg::B_SUM;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                afb_pkg::B_BODY:
                begin
                    state_next = head_cmd.last ? afb_pkg::B_SUM : afb_pkg::B_NEXT;
                end
                afb_pkg::B_SUM:
                begin
                    state_next = afb_pkg::B_NEXT;
                end
                default:
                begin
                    state_next = afb_pkg::B_NEXT;
                end
            endcase
        end
    end

    // Running checksum and output register
    always_comb
    begin
        sum_next   = sum_reg;
        valid_next = valid_reg;
        if (adv)
        begin
            valid_next = emit;
            if (clear_sum)
            begin
                sum_next = 8'd0;
            end
            else if (summed)
            begin
                sum_next = sum_reg + emit_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= afb_pkg::B_NEXT;
            step_reg  <= '0;
            sum_reg   <= 8'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    // Load the output payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byte_reg <= emit_byte;
            end_reg  <= emit_end;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_end   = end_reg;

endmodule

// File: sv/api_frame_builder_top.sv
// Path: accepted items wait in the command queue; bytes leave via the output register.
// Throughput: one frame byte per cycle while m_tready is high and a command is queued,
// set by the back-end sequencer; content items enter at one per cycle while the command
// queue has room, and header/checksum bursts (up to 19 bytes per item) back up into it.
// Reset: asynchronous, active low; clears the queue, sequencer, checksum and
// content count, and loads the configuration registers with their defaults.
module api_frame_builder_top #(
    parameter int MAX_DATA    = 241,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_length, [15:8] byte_value
    input  logic [2:0]  s_tuser,   // [1:0] mode, [2] first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    afb_pkg::cfg_t   cfg_reg;
    afb_pkg::cmd_t   push_cmd, head_cmd;
    logic            push, pop, head_valid, q_full;
    logic [CW-1:0]   q_level;
    logic [7:0]      remaining;
    logic            in_fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_address    <= 64'd0;
            cfg_reg.transmit_type   <= 8'd16;
            cfg_reg.local_cmd_type  <= 8'd8;
            cfg_reg.remote_cmd_type <= 8'd23;
        end
        else if (cfg_we)
        begin
            unique case (afb_pkg::reg_index_t'(cfg_index))
                afb_pkg::REG_DEST_ADDRESS:    cfg_reg.dest_address    <= cfg_data;
                afb_pkg::REG_TRANSMIT_TYPE:   cfg_reg.transmit_type   <= cfg_data[7:0];
                afb_pkg::REG_LOCAL_CMD_TYPE:  cfg_reg.local_cmd_type  <= cfg_data[7:0];
                afb_pkg::REG_REMOTE_CMD_TYPE: cfg_reg.remote_cmd_type <= cfg_data[7:0];
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    afb_front #(
        .MAX_DATA (MAX_DATA)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_mode   (afb_pkg::mode_t'(s_tuser[1:0])),
        .in_first  (s_tuser[2]),
        .in_length (s_tdata[7:0]),
        .in_byte   (s_tdata[15:8]),
        .push      (push),
        .cmd       (push_cmd),
        .remaining (remaining)
    );

    afb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (q_full),
        .level      (q_level)
    );

    afb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_end    (m_tlast)
    );

    // Back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty command queue");

    // Queue occupancy stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n) q_level <= CW'(QUEUE_DEPTH))
        else $error("command queue overflow");

    // Content bytes owed never reach the clipped maximum
    assert property (@(posedge clk) disable iff (!rst_n) remaining < 8'(MAX_DATA))
        else $error("content count out of range");

    // A checksum byte is only loaded after a frame byte preceded it
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast && !$past(m_tvalid && m_tlast && !m_tready)) |->
            $past(m_tvalid))
        else $error("checksum without preceding frame byte");

endmodule
